// ===== rtl/core/mirk_pkg.sv =====
// Shared package for the image mirror / kaleidoscope core.
// Holds register indexes, mode and command codes, reset values and shared structs.
// No dependencies.
package mirk_pkg;

   localparam int DEF_MAX_SIDE = 256;

   localparam int CSR_W      = 9;
   localparam int CSR_ADDR_W = 2;
   localparam int MODE_W     = 2;
   localparam int PIX_W      = 8;

   // register indexes on the csr port
   localparam logic [CSR_ADDR_W-1:0] REG_SRC_WIDTH   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SRC_HEIGHT  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_MIRROR_MODE = 2'd2;

   // mirror modes
   localparam logic [MODE_W-1:0] MODE_MIRROR_X = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MIRROR_Y = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUAD     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_OCTA     = 2'd3;

   // request commands
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EMIT = 1'b1;

   localparam logic [CSR_W-1:0]  RST_SRC_WIDTH   = 9'd256;
   localparam logic [CSR_W-1:0]  RST_SRC_HEIGHT  = 9'd256;
   localparam logic [MODE_W-1:0] RST_MIRROR_MODE = MODE_OCTA;

   typedef struct packed {
      logic [CSR_W-1:0]  src_width;
      logic [CSR_W-1:0]  src_height;
      logic [MODE_W-1:0] mirror_mode;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic emit;
   } step_type;

endpackage

// ===== rtl/core/mirk_store.sv =====
// Frame store: single-port-write, single-port-read synchronous memory.
// Read data is registered. Depends on mirk_pkg.
module mirk_store #(
   parameter int MAX_SIDE = mirk_pkg::DEF_MAX_SIDE
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] wr_addr,
   input  logic [mirk_pkg::PIX_W-1:0]       wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] rd_addr,
   output logic [mirk_pkg::PIX_W-1:0]       rd_data
);

   localparam int DEPTH = MAX_SIDE * MAX_SIDE;

   logic [mirk_pkg::PIX_W-1:0] mem [DEPTH];
   logic [mirk_pkg::PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/mirk_geom.sv =====
// Geometry and position tracking: clamped image sizes, load index, emit
// raster position and the fold of each output pixel back to a source pixel.
// Depends on mirk_pkg.
module mirk_geom #(
   parameter int MAX_SIDE = mirk_pkg::DEF_MAX_SIDE
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mirk_pkg::cfg_type                    cfg,
   input  mirk_pkg::step_type                   step,
   output logic [$clog2(MAX_SIDE+1)-1:0]        side_w,
   output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] load_addr,
   output logic [$clog2(MAX_SIDE)-1:0]          src_x,
   output logic [$clog2(MAX_SIDE)-1:0]          src_y,
   output logic                                 last
);

   localparam int SW  = $clog2(MAX_SIDE + 1);
   localparam int XW  = $clog2(MAX_SIDE);
   localparam int CW  = $clog2(2 * MAX_SIDE + 1);
   localparam int AW  = $clog2(MAX_SIDE * MAX_SIDE);
   localparam int ARW = $clog2(MAX_SIDE * MAX_SIDE + 1);
   localparam int EW  = (mirk_pkg::CSR_W > SW) ? mirk_pkg::CSR_W : SW;

   // sizes, registered from the csr values
   logic [SW-1:0]   w_s, h_s;
   logic [EW-1:0]   wext_s, hext_s;
   logic [2*SW-1:0] area_s;
   logic [SW-1:0]   w_ff, h_ff;
   logic [CW-1:0]   ow_in, oh_in, ow_ff, oh_ff;
   logic [ARW-1:0]  area_ff;
   logic [mirk_pkg::MODE_W-1:0] mode_ff;

   always_comb begin
      wext_s = EW'(cfg.src_width);
      hext_s = EW'(cfg.src_height);
      if (wext_s == '0) begin
         w_s = SW'(1);
      end else if (wext_s > EW'(MAX_SIDE)) begin
         w_s = SW'(MAX_SIDE);
      end else begin
         w_s = SW'(wext_s);
      end
      if (cfg.mirror_mode == mirk_pkg::MODE_OCTA) begin
         h_s = w_s;
      end else if (hext_s == '0) begin
         h_s = SW'(1);
      end else if (hext_s > EW'(MAX_SIDE)) begin
         h_s = SW'(MAX_SIDE);
      end else begin
         h_s = SW'(hext_s);
      end
      ow_in  = (cfg.mirror_mode == mirk_pkg::MODE_MIRROR_Y) ? CW'(w_s) : CW'({w_s, 1'b0});
      oh_in  = (cfg.mirror_mode == mirk_pkg::MODE_MIRROR_X) ? CW'(h_s) : CW'({h_s, 1'b0});
      area_s = (2*SW)'(w_s) * (2*SW)'(h_s);
   end

   always_ff @(posedge clock) begin
      w_ff    <= w_s;
      h_ff    <= h_s;
      ow_ff   <= ow_in;
      oh_ff   <= oh_in;
      area_ff <= ARW'(area_s);
      mode_ff <= cfg.mirror_mode;
   end

   // load index
   logic [AW-1:0]  li_ff, li_in, li_s;
   logic [ARW-1:0] li_p1;

   always_comb begin
      li_s  = (ARW'(li_ff) >= area_ff) ? '0 : li_ff;
      li_p1 = ARW'(li_s) + ARW'(1);
      li_in = li_ff;
      if (step.load) begin
         li_in = (li_p1 >= area_ff) ? '0 : AW'(li_p1);
      end
   end

   // emit position and fold
   logic [CW-1:0] col_ff, col_in, row_ff, row_in;
   logic [CW-1:0] col_s, row_s, col_p1, row_p1, fx_s, fy_s;
   logic [XW-1:0] fxn_s, fyn_s;

   always_comb begin
      // restart when a size change left the position outside the image
      if (col_ff >= ow_ff || row_ff >= oh_ff) begin
         col_s = '0;
         row_s = '0;
      end else begin
         col_s = col_ff;
         row_s = row_ff;
      end

      if (mode_ff == mirk_pkg::MODE_MIRROR_Y || col_s < CW'(w_ff)) begin
         fx_s = col_s;
      end else begin
         fx_s = CW'({w_ff, 1'b0}) - CW'(1) - col_s;
      end
      if (mode_ff == mirk_pkg::MODE_MIRROR_X || row_s < CW'(h_ff)) begin
         fy_s = row_s;
      end else begin
         fy_s = CW'({h_ff, 1'b0}) - CW'(1) - row_s;
      end
      fxn_s = XW'(fx_s);
      fyn_s = XW'(fy_s);

      if (mode_ff == mirk_pkg::MODE_OCTA && fxn_s >= fyn_s) begin
         src_x = fyn_s;
         src_y = fxn_s;
      end else begin
         src_x = fxn_s;
         src_y = fyn_s;
      end

      last = (col_s == ow_ff - CW'(1)) && (row_s == oh_ff - CW'(1));

      col_p1 = col_s + CW'(1);
      row_p1 = row_s + CW'(1);
      col_in = col_ff;
      row_in = row_ff;
      if (step.emit) begin
         if (col_p1 >= ow_ff) begin
            col_in = '0;
            row_in = (row_p1 >= oh_ff) ? '0 : row_p1;
         end else begin
            col_in = col_p1;
            row_in = row_s;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         li_ff  <= '0;
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         li_ff  <= li_in;
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign side_w    = w_ff;
   assign load_addr = li_s;

endmodule

// ===== rtl/core/image_mirror_kaleidoscope_core.sv =====
// Mirror / kaleidoscope core for 8-bit grey images, top level.
// Load requests fill a frame store in raster order; emit requests return the mirrored
// output image pixel by pixel. An emit request folds its output position in the accepting
// cycle; the result then passes address multiply (row times width), frame store read and
// output load, which waits while the output register is still full. One request is in
// flight at a time; the next is accepted in the cycle after the result has moved to the
// output register, even if it is not yet taken. After reset and after each csr write the
// request side is held off while the image sizes settle.
// Depends on mirk_pkg, mirk_geom, mirk_store.
module image_mirror_kaleidoscope_core #(
   parameter int MAX_SIDE = mirk_pkg::DEF_MAX_SIDE
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mirk_pkg::PIX_W-1:0]         req_tdata,  // [7:0] pixel_in
   input  logic                               req_tuser,  // [0] cmd
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [mirk_pkg::PIX_W-1:0]         rsp_tdata,  // [7:0] pixel_out
   output logic                               rsp_tlast,  // last_pixel
   // configuration
   input  logic                               csr_we,
   input  logic [mirk_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [mirk_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int SW = $clog2(MAX_SIDE + 1);
   localparam int XW = $clog2(MAX_SIDE);
   localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);
   localparam int PW = XW + SW;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ADDR = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_DATA = 2'd3;

   // csr registers
   mirk_pkg::cfg_type cfg_ff;
   logic              hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width   <= mirk_pkg::RST_SRC_WIDTH;
         cfg_ff.src_height  <= mirk_pkg::RST_SRC_HEIGHT;
         cfg_ff.mirror_mode <= mirk_pkg::RST_MIRROR_MODE;
         hold_ff            <= 1'b1;
      end else begin
         hold_ff <= csr_we;
         if (csr_we) begin
            case (csr_addr)
               mirk_pkg::REG_SRC_WIDTH:   cfg_ff.src_width   <= csr_wdata;
               mirk_pkg::REG_SRC_HEIGHT:  cfg_ff.src_height  <= csr_wdata;
               mirk_pkg::REG_MIRROR_MODE: cfg_ff.mirror_mode <= csr_wdata[mirk_pkg::MODE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // control
   logic [1:0]          state_ff, state_in;
   logic                accept;
   mirk_pkg::step_type  step;
   logic [SW-1:0]       side_w;
   logic [AW-1:0]       load_addr;
   logic [XW-1:0]       src_x, src_y, sx_ff, sy_ff;
   logic                last, last_ff;
   logic [PW-1:0]       prod;
   logic [AW-1:0]       addr_ff;
   logic [mirk_pkg::PIX_W-1:0] rd_data;
   logic                out_free;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [mirk_pkg::PIX_W-1:0] rsp_data_ff;
   logic                rsp_last_ff;

   assign req_tready = (state_ff == ST_IDLE) && !hold_ff;
   assign accept     = req_tvalid && req_tready;
   assign step.load  = accept && (req_tuser == mirk_pkg::CMD_LOAD);
   assign step.emit  = accept && (req_tuser == mirk_pkg::CMD_EMIT);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign prod       = PW'(sy_ff) * PW'(side_w);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (step.emit) state_in = ST_ADDR;
         ST_ADDR: state_in = ST_READ;
         ST_READ: state_in = ST_DATA;
         ST_DATA: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_DATA && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step.emit) begin
         sx_ff   <= src_x;
         sy_ff   <= src_y;
         last_ff <= last;
      end
      if (state_ff == ST_ADDR) begin
         addr_ff <= AW'(prod + PW'(sx_ff));
      end
      if (state_ff == ST_DATA && out_free) begin
         rsp_data_ff <= rd_data;
         rsp_last_ff <= last_ff;
      end
   end

   mirk_geom #(
      .MAX_SIDE(MAX_SIDE)
   ) u_geom (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .step      (step),
      .side_w    (side_w),
      .load_addr (load_addr),
      .src_x     (src_x),
      .src_y     (src_y),
      .last      (last)
   );

   mirk_store #(
      .MAX_SIDE(MAX_SIDE)
   ) u_store (
      .clock   (clock),
      .wr_en   (step.load),
      .wr_addr (load_addr),
      .wr_data (req_tdata),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for image_mirror_kaleidoscope_core: load and emit requests
// against a behavioral mirror/kaleidoscope predictor, random idling on both streams.
// Depends on mirk_pkg and the core RTL only.
module tb;

   localparam int MAX_SIDE    = mirk_pkg::DEF_MAX_SIDE;
   localparam int CSR_W       = mirk_pkg::CSR_W;
   localparam int CSR_ADDR_W  = mirk_pkg::CSR_ADDR_W;
   localparam int MODE_W      = mirk_pkg::MODE_W;
   localparam int PIX_W       = mirk_pkg::PIX_W;
   localparam int ITEM_GOAL   = 1950;
   localparam int CYCLE_LIMIT = 600000;
   localparam int LONG_HOLD   = 60;
   localparam int MAX_AREA    = 512;   // keeps frame loads short
   localparam int OCTA_SIDE   = 12;

   typedef struct packed {
      logic             cmd;
      logic [PIX_W-1:0] pixel;
   } pixel_req_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             last;
   } pixel_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata = '0;     // [7:0] pixel_in
   logic                  req_tuser = mirk_pkg::CMD_LOAD; // [0] cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [PIX_W-1:0]      rsp_tdata;          // [7:0] pixel_out
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_W-1:0]      csr_wdata = '0;

   image_mirror_kaleidoscope_core #(.MAX_SIDE(MAX_SIDE)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // predictor state
   logic [PIX_W-1:0]  frame_mem [MAX_SIDE*MAX_SIDE];
   logic [CSR_W-1:0]  cfg_width  = mirk_pkg::RST_SRC_WIDTH;
   logic [CSR_W-1:0]  cfg_height = mirk_pkg::RST_SRC_HEIGHT;
   logic [MODE_W-1:0] cfg_mode   = mirk_pkg::RST_MIRROR_MODE;
   int                load_pos = 0;
   int                emit_x = 0;
   int                emit_y = 0;

   pixel_req_type    pending_reqs[$];
   pixel_result_type expected_pixels[$];
   pixel_req_type    nxt;
   pixel_result_type want;

   int reqs_queued = 0;
   int reqs_accepted = 0;
   int results_seen = 0;
   int errors = 0;
   int cycles = 0;
   int send_gap = 0;
   int recv_stall = 0;
   int send_idle_pct = 25;
   int recv_idle_pct = 25;
   bit calm = 1'b0;
   bit long_hold_done = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int side_of(input logic [CSR_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_SIDE) return MAX_SIDE;
      return int'(v);
   endfunction

   // mostly small sides, now and then a clamped or extreme one
   function automatic logic [CSR_W-1:0] pick_side();
      if ($urandom_range(0, 99) < 85) return CSR_W'($urandom_range(1, 8));
      case ($urandom_range(0, 6))
         0: return 9'd0;
         1: return 9'd1;
         2: return 9'd255;
         3: return 9'd256;
         4: return 9'd257;
         5: return 9'd300;
         default: return 9'd511;
      endcase
   endfunction

   task automatic predict_mirror(input logic cmd, input logic [PIX_W-1:0] pix);
      int w, h, ow, oh, fx, fy, sx, sy;
      pixel_result_type res;
      w  = side_of(cfg_width);
      h  = (cfg_mode == mirk_pkg::MODE_OCTA) ? w : side_of(cfg_height);
      ow = (cfg_mode == mirk_pkg::MODE_MIRROR_Y) ? w : 2 * w;
      oh = (cfg_mode == mirk_pkg::MODE_MIRROR_X) ? h : 2 * h;
      if (cmd == mirk_pkg::CMD_LOAD) begin
         if (load_pos >= w * h) load_pos = 0;
         frame_mem[load_pos] = pix;
         load_pos++;
         if (load_pos >= w * h) load_pos = 0;
      end else begin
         // position left outside a shrunken image restarts at the origin
         if (emit_x >= ow || emit_y >= oh) begin
            emit_x = 0;
            emit_y = 0;
         end
         fx = (emit_x < w) ? emit_x : 2 * w - 1 - emit_x;
         fy = (emit_y < h) ? emit_y : 2 * h - 1 - emit_y;
         if (cfg_mode == mirk_pkg::MODE_OCTA && fx > fy) begin
            sx = fy;
            sy = fx;
         end else begin
            sx = fx;
            sy = fy;
         end
         res.pixel = frame_mem[sy * w + sx];
         res.last  = (emit_x == ow - 1 && emit_y == oh - 1);
         expected_pixels.push_back(res);
         emit_x++;
         if (emit_x >= ow) begin
            emit_x = 0;
            emit_y++;
            if (emit_y >= oh) emit_y = 0;
         end
      end
   endtask

   task automatic queue_req(input logic cmd, input logic [PIX_W-1:0] pix);
      pixel_req_type r;
      r.cmd   = cmd;
      r.pixel = pix;
      pending_reqs.push_back(r);
      reqs_queued++;
   endtask

   // waits until all requests are taken and all pixels are back, then idles for a trailing load
   task automatic settle();
      while (reqs_accepted != reqs_queued || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      case (idx)
         mirk_pkg::REG_SRC_WIDTH:   cfg_width  = val;
         mirk_pkg::REG_SRC_HEIGHT:  cfg_height = val;
         mirk_pkg::REG_MIRROR_MODE: cfg_mode   = val[MODE_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_mirror(req_tuser, req_tdata);
            reqs_accepted++;
            if (reqs_accepted % 64 == 0) send_idle_pct = $urandom_range(0, 2) * 25;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               nxt = pending_reqs.pop_front();
               req_tuser  <= nxt.cmd;
               req_tdata  <= nxt.pixel;
               req_tvalid <= 1'b1;
               if (!calm && $urandom_range(0, 99) < send_idle_pct)
                  send_gap = $urandom_range(1, 3);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (results_seen % 64 == 0) recv_idle_pct = $urandom_range(0, 2) * 25;
            if (expected_pixels.size() == 0) begin
               errors++;
               $display("%0t: unexpected pixel: expected none, actual %02h last %0b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_tdata !== want.pixel) begin
                  errors++;
                  $display("%0t: pixel_out: expected %02h, actual %02h",
                           $time, want.pixel, rsp_tdata);
               end
               if (rsp_tlast !== want.last) begin
                  errors++;
                  $display("%0t: last_pixel: expected %0b, actual %0b",
                           $time, want.last, rsp_tlast);
               end
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && results_seen >= 200
                      && reqs_queued - reqs_accepted > 4) begin
            // long back-pressure while requests keep coming
            long_hold_done = 1'b1;
            recv_stall = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < recv_idle_pct) begin
            recv_stall = $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int w, h, ow, oh, area, out_size, k, loaded_span;
      logic [2:0]        mask;
      logic [CSR_W-1:0]  new_w, new_h;
      logic [MODE_W-1:0] new_m;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // 2x2 source in four-fold mode, full output plus wrap past the last pixel
      write_csr(mirk_pkg::REG_SRC_WIDTH, 9'd2);
      write_csr(mirk_pkg::REG_SRC_HEIGHT, 9'd2);
      write_csr(mirk_pkg::REG_MIRROR_MODE, {{(CSR_W-MODE_W){1'b0}}, mirk_pkg::MODE_QUAD});
      queue_req(mirk_pkg::CMD_LOAD, 8'h00);
      queue_req(mirk_pkg::CMD_LOAD, 8'hFF);
      queue_req(mirk_pkg::CMD_LOAD, 8'h5A);
      queue_req(mirk_pkg::CMD_LOAD, 8'hA5);
      repeat (19) queue_req(mirk_pkg::CMD_EMIT, 8'h00);
      loaded_span = 4;
      settle();
      // narrower output leaves the emit column outside the image
      write_csr(mirk_pkg::REG_MIRROR_MODE,
                {{(CSR_W-MODE_W){1'b0}}, mirk_pkg::MODE_MIRROR_Y});
      repeat (2) queue_req(mirk_pkg::CMD_EMIT, 8'hFF);

      while (reqs_queued < ITEM_GOAL) begin
         if (reqs_queued > ITEM_GOAL * 4 / 5) calm = 1'b1;
         settle();
         mask  = 3'($urandom_range(1, 7));
         new_w = mask[0] ? pick_side() : cfg_width;
         new_h = mask[1] ? pick_side() : cfg_height;
         new_m = mask[2] ? MODE_W'($urandom_range(0, 3)) : cfg_mode;
         if (new_m == mirk_pkg::MODE_OCTA && side_of(new_w) > OCTA_SIDE) begin
            new_w = CSR_W'($urandom_range(1, OCTA_SIDE));
            mask[0] = 1'b1;
         end
         if (new_m != mirk_pkg::MODE_OCTA
             && side_of(new_w) * side_of(new_h) > MAX_AREA) begin
            if (side_of(new_w) > side_of(new_h)) begin
               new_h = CSR_W'($urandom_range(0, 2));
               mask[1] = 1'b1;
            end else begin
               new_w = CSR_W'($urandom_range(0, 2));
               mask[0] = 1'b1;
            end
         end
         if (mask[0]) write_csr(mirk_pkg::REG_SRC_WIDTH, new_w);
         if (mask[1]) write_csr(mirk_pkg::REG_SRC_HEIGHT, new_h);
         if (mask[2]) write_csr(mirk_pkg::REG_MIRROR_MODE, {{(CSR_W-MODE_W){1'b0}}, new_m});

         w  = side_of(cfg_width);
         h  = (cfg_mode == mirk_pkg::MODE_OCTA) ? w : side_of(cfg_height);
         ow = (cfg_mode == mirk_pkg::MODE_MIRROR_Y) ? w : 2 * w;
         oh = (cfg_mode == mirk_pkg::MODE_MIRROR_X) ? h : 2 * h;
         area = w * h;
         out_size = ow * oh;

         if ($urandom_range(0, 9) == 0) begin
            // abandoned frame: partial load only
            k = $urandom_range(1, area);
            repeat (k) queue_req(mirk_pkg::CMD_LOAD, PIX_W'($urandom_range(0, 255)));
         end else begin
            // a full frame is needed whenever the image reaches past what was loaded
            if (area > loaded_span || $urandom_range(0, 9) < 6) begin
               repeat (area) queue_req(mirk_pkg::CMD_LOAD, PIX_W'($urandom_range(0, 255)));
               if (area > loaded_span) loaded_span = area;
            end
            k = $urandom_range(1, out_size + out_size / 2);
            if (k > 300) k = 300;
            repeat (k)
               queue_req(($urandom_range(0, 3) == 0) ? mirk_pkg::CMD_LOAD : mirk_pkg::CMD_EMIT,
                         PIX_W'($urandom_range(0, 255)));
         end
      end

      calm = 1'b1;
      settle();
      repeat (12) @(posedge clock);
      if (errors == 0 && expected_pixels.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
